[design/ssfs_pkg.sv]
// ----------------------------------------------------------------------------
// ssfs_pkg - shared types and constants of the seven segment frame sequencer
// Command and frame kind codes, queue entry and configuration structs,
// segment table and decimal reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfs_pkg;

   // input commands
   localparam logic [2:0] CMD_FOUR_DIGITS = 3'd0;
   localparam logic [2:0] CMD_FOUR_RAW    = 3'd1;
   localparam logic [2:0] CMD_ONE_DIGIT   = 3'd2;
   localparam logic [2:0] CMD_ONE_RAW     = 3'd3;
   localparam logic [2:0] CMD_INTEGER     = 3'd4;
   localparam logic [2:0] CMD_CLOCK       = 3'd5;
   localparam logic [2:0] CMD_REFRESH     = 3'd6;
   localparam logic [2:0] CMD_CLEAR       = 3'd7;

   // frame kinds carried through the queue
   localparam logic [1:0] KIND_FOUR  = 2'd0;
   localparam logic [1:0] KIND_ONE   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_BRIGHTNESS  = 3'd0;
   localparam logic [2:0] REG_POINT_ON    = 3'd1;
   localparam logic [2:0] REG_START_ADDR  = 3'd2;
   localparam logic [2:0] REG_AUTO_DATA   = 3'd3;
   localparam logic [2:0] REG_FIXED_DATA  = 3'd4;
   localparam int         CSR_ADDR_W      = 5;

   // reset values of the configuration registers
   localparam logic [2:0] BRIGHTNESS_RST  = 3'd7;
   localparam logic [7:0] START_ADDR_RST  = 8'hc0;
   localparam logic [7:0] AUTO_DATA_RST   = 8'h40;
   localparam logic [7:0] FIXED_DATA_RST  = 8'h44;

   // bus byte constants
   localparam logic [7:0] CTRL_BASE        = 8'h88;
   localparam logic [7:0] SINGLE_ADDR_BASE = 8'hc0;
   localparam logic [7:0] POINT_BIT        = 8'h80;
   localparam logic [7:0] SEG_BLANK        = 8'h00;

   // digit codes
   localparam logic [3:0] CODE_BLANK = 4'd10;
   localparam logic [3:0] CODE_MINUS = 4'd11;

   // accepted ranges
   localparam logic [14:0] INT_POS_MAX = 15'd9999;
   localparam logic [14:0] INT_NEG_MAX = 15'd999;
   localparam logic [6:0]  CLOCK_MAX   = 7'd99;

   // reciprocals: x / d == (x * R) >> S over the accepted ranges
   localparam logic [13:0] RECIP_1000 = 14'd8389;   // >> 23, x < 10000
   localparam logic [13:0] RECIP_100  = 14'd5243;   // >> 19, x < 10000
   localparam logic [13:0] RECIP_10   = 14'd6554;   // >> 16, x < 10000
   localparam logic [7:0]  RECIP_10_S = 8'd205;     // >> 11, x < 100

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef struct packed {
      logic [1:0]      kind;
      logic [1:0]      pos;
      logic [3:0][7:0] seg;
   } entry_type;

   typedef struct packed {
      logic [2:0] brightness;
      logic       point_on;
      logic [7:0] start_address_cmd;
      logic [7:0] auto_data_cmd;
      logic [7:0] fixed_data_cmd;
   } cfg_type;

   function automatic logic [7:0] code_to_seg(input logic [7:0] code);
      logic [7:0] seg;
      case (code)
         8'd0:    seg = 8'h3f;
         8'd1:    seg = 8'h06;
         8'd2:    seg = 8'h5b;
         8'd3:    seg = 8'h4f;
         8'd4:    seg = 8'h66;
         8'd5:    seg = 8'h6d;
         8'd6:    seg = 8'h7d;
         8'd7:    seg = 8'h07;
         8'd8:    seg = 8'h7f;
         8'd9:    seg = 8'h6f;
         8'd11:   seg = 8'h40;
         default: seg = SEG_BLANK;   // blank code and anything above minus
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

[design/ssfs_front.sv]
// ----------------------------------------------------------------------------
// ssfs_front - command intake and formatting
// Two stages: range checks and decimal quotients, then digit formatting,
// blanking and segment lookup. Keeps the stored segments and pushes one
// frame entry per in-range command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfs_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [2:0]              req_cmd,
   input  wire logic [1:0]              req_position,
   input  wire logic [7:0]              req_slot0,
   input  wire logic [7:0]              req_slot1,
   input  wire logic [7:0]              req_slot2,
   input  wire logic [7:0]              req_slot3,
   input  wire logic signed [14:0]      req_number,
   input  wire logic [6:0]              req_hours,
   input  wire logic [6:0]              req_minutes,
   output logic                         q_push,
   output ssfs_pkg::entry_type          q_entry,
   input  wire logic                    q_full
);

   function automatic logic [13:0] times_ten(input logic [13:0] x);
      return (x << 3) + (x << 1);
   endfunction

   // ---------------- stage 1: captured command ----------------
   logic                    s1_valid_ff;
   logic [2:0]              s1_cmd_ff;
   logic [1:0]              s1_pos_ff;
   logic [3:0][7:0]         s1_slot_ff;
   logic [14:0]             s1_number_ff;
   logic [6:0]              s1_hours_ff;
   logic [6:0]              s1_minutes_ff;

   // ---------------- stage 2: quotients ----------------
   logic                    s2_valid_ff;
   logic [2:0]              s2_cmd_ff;
   logic [1:0]              s2_pos_ff;
   logic [3:0][7:0]         s2_slot_ff;
   logic                    s2_neg_ff;
   logic                    s2_int_ok_ff;
   logic                    s2_clk_ok_ff;
   logic [13:0]             s2_abs_ff;
   logic [3:0]              s2_q1000_ff;
   logic [6:0]              s2_q100_ff;
   logic [9:0]              s2_q10_ff;
   logic [6:0]              s2_hours_ff;
   logic [6:0]              s2_minutes_ff;
   logic [3:0]              s2_hq_ff;
   logic [3:0]              s2_mq_ff;

   logic [3:0][7:0]         last_seg_ff;
   logic [3:0][7:0]         last_seg_in;

   logic                    s1_take;
   logic                    s2_take;
   logic                    s2_done;
   logic                    s2_drop;

   // stage 1 combinational
   logic                    s1_neg;
   logic [14:0]             s1_abs;
   logic                    s1_int_ok;
   logic                    s1_clk_ok;
   logic [27:0]             p1000;
   logic [27:0]             p100;
   logic [27:0]             p10;
   logic [14:0]             ph;
   logic [14:0]             pm;

   assign s1_neg    = s1_number_ff[14];
   assign s1_abs    = s1_neg ? (15'd0 - s1_number_ff) : s1_number_ff;
   assign s1_int_ok = s1_neg ? (s1_abs <= ssfs_pkg::INT_NEG_MAX)
                             : (s1_abs <= ssfs_pkg::INT_POS_MAX);
   assign s1_clk_ok = (s1_hours_ff <= ssfs_pkg::CLOCK_MAX) &&
                      (s1_minutes_ff <= ssfs_pkg::CLOCK_MAX);
   assign p1000 = {14'd0, s1_abs[13:0]} * {14'd0, ssfs_pkg::RECIP_1000};
   assign p100  = {14'd0, s1_abs[13:0]} * {14'd0, ssfs_pkg::RECIP_100};
   assign p10   = {14'd0, s1_abs[13:0]} * {14'd0, ssfs_pkg::RECIP_10};
   assign ph    = {8'd0, s1_hours_ff} * {7'd0, ssfs_pkg::RECIP_10_S};
   assign pm    = {8'd0, s1_minutes_ff} * {7'd0, ssfs_pkg::RECIP_10_S};

   // pipeline control
   assign s2_drop = ((s2_cmd_ff == ssfs_pkg::CMD_INTEGER) && !s2_int_ok_ff) ||
                    ((s2_cmd_ff == ssfs_pkg::CMD_CLOCK) && !s2_clk_ok_ff);
   assign s2_done = s2_valid_ff && (s2_drop || !q_full);
   assign q_push  = s2_valid_ff && !s2_drop && !q_full;
   assign s2_take = !s2_valid_ff || s2_done;
   assign s1_take = !s1_valid_ff || s2_take;
   assign req_stall = !s1_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_take) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_cmd_ff     <= req_cmd;
         s1_pos_ff     <= req_position;
         s1_slot_ff    <= {req_slot3, req_slot2, req_slot1, req_slot0};
         s1_number_ff  <= req_number;
         s1_hours_ff   <= req_hours;
         s1_minutes_ff <= req_minutes;
      end
      if (s2_take) begin
         s2_cmd_ff     <= s1_cmd_ff;
         s2_pos_ff     <= s1_pos_ff;
         s2_slot_ff    <= s1_slot_ff;
         s2_neg_ff     <= s1_neg;
         s2_int_ok_ff  <= s1_int_ok;
         s2_clk_ok_ff  <= s1_clk_ok;
         s2_abs_ff     <= s1_abs[13:0];
         s2_q1000_ff   <= p1000[26:23];
         s2_q100_ff    <= p100[25:19];
         s2_q10_ff     <= p10[25:16];
         s2_hours_ff   <= s1_hours_ff;
         s2_minutes_ff <= s1_minutes_ff;
         s2_hq_ff      <= ph[14:11];
         s2_mq_ff      <= pm[14:11];
      end
   end

   // stage 2: digits of the integer
   logic [3:0] d0, d1, d2, d3;
   logic [3:0] c0, c1, c2, c3;
   logic [3:0] hd0, hd1, md0, md1;
   logic [13:0] t1, t2, t3;

   assign t1 = {7'd0, s2_q100_ff} - times_ten({10'd0, s2_q1000_ff});
   assign t2 = {4'd0, s2_q10_ff} - times_ten({7'd0, s2_q100_ff});
   assign t3 = s2_abs_ff - times_ten({4'd0, s2_q10_ff});
   assign d0 = s2_q1000_ff;
   assign d1 = t1[3:0];
   assign d2 = t2[3:0];
   assign d3 = t3[3:0];

   // leading zero blanking; minus just left of the first nonzero digit
   always_comb begin
      c0 = d0;
      c1 = d1;
      c2 = d2;
      c3 = d3;
      if (d0 == 4'd0) begin
         if (s2_neg_ff && (d1 != 4'd0)) begin
            c0 = ssfs_pkg::CODE_MINUS;
         end else begin
            c0 = ssfs_pkg::CODE_BLANK;
            if (d1 == 4'd0) begin
               if (s2_neg_ff && (d2 != 4'd0)) begin
                  c1 = ssfs_pkg::CODE_MINUS;
               end else begin
                  c1 = ssfs_pkg::CODE_BLANK;
                  if (d2 == 4'd0) begin
                     c2 = (s2_neg_ff && (d3 != 4'd0)) ? ssfs_pkg::CODE_MINUS
                                                     : ssfs_pkg::CODE_BLANK;
                  end
               end
            end
         end
      end
   end

   // clock digits; hour tens blank when zero
   logic [13:0] th, tm;
   assign th  = {7'd0, s2_hours_ff} - times_ten({10'd0, s2_hq_ff});
   assign tm  = {7'd0, s2_minutes_ff} - times_ten({10'd0, s2_mq_ff});
   assign hd0 = (s2_hq_ff == 4'd0) ? ssfs_pkg::CODE_BLANK : s2_hq_ff;
   assign hd1 = th[3:0];
   assign md0 = s2_mq_ff;
   assign md1 = tm[3:0];

   // entry build
   always_comb begin
      q_entry.kind = ssfs_pkg::KIND_FOUR;
      q_entry.pos  = s2_pos_ff;
      q_entry.seg  = s2_slot_ff;
      case (s2_cmd_ff)
         ssfs_pkg::CMD_FOUR_DIGITS: begin
            for (int i = 0; i < 4; i++) begin
               q_entry.seg[i] = ssfs_pkg::code_to_seg(s2_slot_ff[i]);
            end
         end
         ssfs_pkg::CMD_FOUR_RAW: begin
            q_entry.seg = s2_slot_ff;
         end
         ssfs_pkg::CMD_ONE_DIGIT: begin
            q_entry.kind   = ssfs_pkg::KIND_ONE;
            q_entry.seg[0] = ssfs_pkg::code_to_seg(s2_slot_ff[0]);
         end
         ssfs_pkg::CMD_ONE_RAW: begin
            q_entry.kind = ssfs_pkg::KIND_ONE;
         end
         ssfs_pkg::CMD_INTEGER: begin
            q_entry.seg[0] = ssfs_pkg::code_to_seg({4'd0, c0});
            q_entry.seg[1] = ssfs_pkg::code_to_seg({4'd0, c1});
            q_entry.seg[2] = ssfs_pkg::code_to_seg({4'd0, c2});
            q_entry.seg[3] = ssfs_pkg::code_to_seg({4'd0, c3});
         end
         ssfs_pkg::CMD_CLOCK: begin
            q_entry.seg[0] = ssfs_pkg::code_to_seg({4'd0, hd0});
            q_entry.seg[1] = ssfs_pkg::code_to_seg({4'd0, hd1});
            q_entry.seg[2] = ssfs_pkg::code_to_seg({4'd0, md0});
            q_entry.seg[3] = ssfs_pkg::code_to_seg({4'd0, md1});
         end
         ssfs_pkg::CMD_REFRESH: begin
            q_entry.seg = last_seg_ff;
         end
         default: begin
            q_entry.kind = ssfs_pkg::KIND_CLEAR;
            q_entry.seg  = '0;
         end
      endcase
   end

   // stored segments follow the frames in command order
   always_comb begin
      last_seg_in = last_seg_ff;
      case (q_entry.kind)
         ssfs_pkg::KIND_FOUR:  last_seg_in = q_entry.seg;
         ssfs_pkg::KIND_ONE:   last_seg_in[q_entry.pos] = q_entry.seg[0];
         default:              last_seg_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seg_ff <= '0;
      end else if (q_push) begin
         last_seg_ff <= last_seg_in;
      end
   end

endmodule

`default_nettype wire

[design/ssfs_queue.sv]
// ----------------------------------------------------------------------------
// ssfs_queue - frame entry queue
// Small FIFO between formatting and byte sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfs_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ssfs_pkg::entry_type  push_entry,
   output logic                      full,
   input  wire logic                 pop,
   output ssfs_pkg::entry_type       pop_entry,
   output logic                      not_empty
);

   ssfs_pkg::entry_type entries_ff [ssfs_pkg::QUEUE_DEPTH];
   logic [ssfs_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ssfs_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ssfs_pkg::QUEUE_PTR_W:0]   count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (count_ff == (ssfs_pkg::QUEUE_PTR_W+1)'(ssfs_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_entry = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + {{ssfs_pkg::QUEUE_PTR_W{1'b0}}, do_push}
                               - {{ssfs_pkg::QUEUE_PTR_W{1'b0}}, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[design/ssfs_back.sv]
// ----------------------------------------------------------------------------
// ssfs_back - bus byte sequencer
// Walks one queued frame entry a byte per cycle into the result register while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfs_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ssfs_pkg::cfg_type    cfg,
   input  wire logic                 q_not_empty,
   input  wire ssfs_pkg::entry_type  q_entry,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_bus_byte,
   output logic                      rsp_start_before,
   output logic                      rsp_stop_after,
   output logic                      rsp_last
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_bus_byte_ff, rsp_bus_byte_in;
   logic       rsp_start_ff, rsp_start_in;
   logic       rsp_stop_ff, rsp_stop_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [3:0] step_ff, step_in;

   logic       out_free;
   logic       fire;
   logic [7:0] ctrl_byte;
   logic [7:0] point_mask;
   logic [1:0] four_idx;
   logic [1:0] one_pos;
   logic [7:0] one_seg;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = q_not_empty && out_free;
   assign ctrl_byte  = ssfs_pkg::CTRL_BASE + {5'd0, cfg.brightness};
   assign point_mask = cfg.point_on ? ssfs_pkg::POINT_BIT : 8'd0;
   assign four_idx   = step_ff[1:0] - 2'd2;
   assign one_pos    = (q_entry.kind == ssfs_pkg::KIND_CLEAR) ? step_ff[3:2] : q_entry.pos;
   assign one_seg    = (q_entry.kind == ssfs_pkg::KIND_CLEAR) ? ssfs_pkg::SEG_BLANK
                                                              : q_entry.seg[0];

   always_comb begin
      rsp_bus_byte_in = ctrl_byte;
      rsp_start_in    = 1'b1;
      rsp_stop_in     = 1'b1;
      rsp_last_in     = 1'b0;
      case (q_entry.kind)
         ssfs_pkg::KIND_FOUR: begin
            rsp_last_in = (step_ff == 4'd6);
            case (step_ff)
               4'd0: rsp_bus_byte_in = cfg.auto_data_cmd;
               4'd1: begin
                  rsp_bus_byte_in = cfg.start_address_cmd;
                  rsp_stop_in     = 1'b0;
               end
               4'd2, 4'd3, 4'd4, 4'd5: begin
                  rsp_bus_byte_in = q_entry.seg[four_idx] ^ point_mask;
                  rsp_start_in    = 1'b0;
                  rsp_stop_in     = (step_ff == 4'd5);
               end
               default: rsp_bus_byte_in = ctrl_byte;
            endcase
         end
         ssfs_pkg::KIND_ONE, ssfs_pkg::KIND_CLEAR: begin
            rsp_last_in = (q_entry.kind == ssfs_pkg::KIND_CLEAR) ? (step_ff == 4'd15)
                                                                 : (step_ff == 4'd3);
            case (step_ff[1:0])
               2'd0: rsp_bus_byte_in = cfg.fixed_data_cmd;
               2'd1: begin
                  rsp_bus_byte_in = ssfs_pkg::SINGLE_ADDR_BASE | {6'd0, one_pos};
                  rsp_stop_in     = 1'b0;
               end
               2'd2: begin
                  rsp_bus_byte_in = one_seg ^ point_mask;
                  rsp_start_in    = 1'b0;
               end
               default: rsp_bus_byte_in = ctrl_byte;
            endcase
         end
         default: rsp_last_in = 1'b1;   // unused kind: never queued
      endcase
   end

   assign q_pop        = fire && rsp_last_in;
   assign step_in      = fire ? (rsp_last_in ? 4'd0 : step_ff + 4'd1) : step_ff;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_bus_byte_ff <= rsp_bus_byte_in;
         rsp_start_ff    <= rsp_start_in;
         rsp_stop_ff     <= rsp_stop_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bus_byte     = rsp_bus_byte_ff;
   assign rsp_start_before = rsp_start_ff;
   assign rsp_stop_after   = rsp_stop_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

[design/seven_segment_frame_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// seven_segment_frame_sequencer_unit - four digit display frame sequencer
// Turns display commands into marked bus bytes for a TM1637-style display.
//
// Request channel (req_*): one command per transfer, valid/stall handshake.
// Response channel (rsp_*): one bus byte per transfer, with start/stop marks;
// rsp_last flags the final byte of a command. Four-position frames give 7
// bytes, single-position frames 4, clear 16; out-of-range integer or clock
// commands give no bytes at all.
// Path: after its request transfer, the first byte of a command passes the
// second formatting stage, the queue write and the result register.
// Throughput: one byte per cycle on the response side while rsp_stall is low;
// the request side keeps taking commands back to back until the 4-entry
// frame queue and the two front stages are full.
// Configuration: APB-style registers at 4*i (brightness, point_on, address
// command, auto and fixed data commands); the user must write them only while idle, not enforced.
// Reset: synchronous; clears the pipeline, queue, stored segments and
// restores register defaults. rsp_stall holds the result register and,
// through the queue, eventually stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_frame_sequencer_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [2:0]                        req_cmd,
   input  wire logic [1:0]                        req_position,
   input  wire logic [7:0]                        req_slot0,
   input  wire logic [7:0]                        req_slot1,
   input  wire logic [7:0]                        req_slot2,
   input  wire logic [7:0]                        req_slot3,
   input  wire logic signed [14:0]                req_number,
   input  wire logic [6:0]                        req_hours,
   input  wire logic [6:0]                        req_minutes,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_bus_byte,
   output logic                                   rsp_start_before,
   output logic                                   rsp_stop_after,
   output logic                                   rsp_last,
   // configuration port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [ssfs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   // ---------------- configuration registers ----------------
   ssfs_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_write;
   logic [2:0]        csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[ssfs_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ssfs_pkg::REG_BRIGHTNESS: cfg_in.brightness        = pwdata[2:0];
            ssfs_pkg::REG_POINT_ON:   cfg_in.point_on          = pwdata[0];
            ssfs_pkg::REG_START_ADDR: cfg_in.start_address_cmd = pwdata[7:0];
            ssfs_pkg::REG_AUTO_DATA:  cfg_in.auto_data_cmd     = pwdata[7:0];
            ssfs_pkg::REG_FIXED_DATA: cfg_in.fixed_data_cmd    = pwdata[7:0];
            default:                  cfg_in = cfg_ff;   // unmapped: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness        <= ssfs_pkg::BRIGHTNESS_RST;
         cfg_ff.point_on          <= 1'b0;
         cfg_ff.start_address_cmd <= ssfs_pkg::START_ADDR_RST;
         cfg_ff.auto_data_cmd     <= ssfs_pkg::AUTO_DATA_RST;
         cfg_ff.fixed_data_cmd    <= ssfs_pkg::FIXED_DATA_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux, zero extended
   always_comb begin
      case (csr_index)
         ssfs_pkg::REG_BRIGHTNESS: prdata = {29'd0, cfg_ff.brightness};
         ssfs_pkg::REG_POINT_ON:   prdata = {31'd0, cfg_ff.point_on};
         ssfs_pkg::REG_START_ADDR: prdata = {24'd0, cfg_ff.start_address_cmd};
         ssfs_pkg::REG_AUTO_DATA:  prdata = {24'd0, cfg_ff.auto_data_cmd};
         ssfs_pkg::REG_FIXED_DATA: prdata = {24'd0, cfg_ff.fixed_data_cmd};
         default:                  prdata = 32'd0;
      endcase
   end

   // ---------------- front: intake and formatting ----------------
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_not_empty;
   ssfs_pkg::entry_type q_push_entry;
   ssfs_pkg::entry_type q_pop_entry;

   ssfs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_slot0    (req_slot0),
      .req_slot1    (req_slot1),
      .req_slot2    (req_slot2),
      .req_slot3    (req_slot3),
      .req_number   (req_number),
      .req_hours    (req_hours),
      .req_minutes  (req_minutes),
      .q_push       (q_push),
      .q_entry      (q_push_entry),
      .q_full       (q_full)
   );

   // ---------------- frame queue ----------------
   ssfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .not_empty  (q_not_empty)
   );

   // ---------------- back: byte sequencing ----------------
   ssfs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_not_empty      (q_not_empty),
      .q_entry          (q_pop_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bus_byte     (rsp_bus_byte),
      .rsp_start_before (rsp_start_before),
      .rsp_stop_after   (rsp_stop_after),
      .rsp_last         (rsp_last)
   );

   // ---------------- assertions ----------------
   // every frame ends on the control byte, which closes with a stop
   a_last_has_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_stop_after && rsp_start_before)
      else $error("final byte of a command without start/stop");

   // an address byte (start, no stop) is never the end of a command
   a_addr_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_before && !rsp_stop_after |-> !rsp_last)
      else $error("command ended on an address byte");

   // nothing is pending on the response side right after reset
   a_reset_clears: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid straight out of reset");

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the seven segment frame sequencer
// Drives display commands through the request channel under random source
// gaps and sink stalls, predicts every bus byte with start/stop marks and
// the end-of-command flag, and checks each response transfer in order.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_LIMIT   = 4000;   // cycles without any transfer
   localparam int RAND_PHASES  = 5;
   localparam int PHASE_CMDS   = 71;
   localparam int HOLD_AT      = 120;    // commands taken before the long sink hold
   localparam int HOLD_LEN     = 250;

   // segment patterns for digit codes 0..9, blank, minus
   localparam logic [11:0][7:0] DIGIT_SEGS = {
      8'h40, 8'h00, 8'h6f, 8'h7f, 8'h07, 8'h7d,
      8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
   };

   typedef struct packed {
      logic [2:0]      cmd;
      logic [1:0]      position;
      logic [3:0][7:0] slot;
      logic [14:0]     number;
      logic [6:0]      hours;
      logic [6:0]      minutes;
   } disp_cmd_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       start_before;
      logic       stop_after;
      logic       last;
   } bus_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd      = '0;
   logic [1:0]  req_position = '0;
   logic [7:0]  req_slot0    = '0;
   logic [7:0]  req_slot1    = '0;
   logic [7:0]  req_slot2    = '0;
   logic [7:0]  req_slot3    = '0;
   logic [14:0] req_number   = '0;
   logic [6:0]  req_hours    = '0;
   logic [6:0]  req_minutes  = '0;

   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [7:0]  rsp_bus_byte;
   logic        rsp_start_before;
   logic        rsp_stop_after;
   logic        rsp_last;

   logic        psel         = 1'b0;
   logic        penable      = 1'b0;
   logic        pwrite       = 1'b0;
   logic [ssfs_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata       = '0;
   logic [31:0] prdata;
   logic        pready;

   seven_segment_frame_sequencer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_position     (req_position),
      .req_slot0        (req_slot0),
      .req_slot1        (req_slot1),
      .req_slot2        (req_slot2),
      .req_slot3        (req_slot3),
      .req_number       (req_number),
      .req_hours        (req_hours),
      .req_minutes      (req_minutes),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bus_byte     (rsp_bus_byte),
      .rsp_start_before (rsp_start_before),
      .rsp_stop_after   (rsp_stop_after),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Display model: register copy, stored segments, expected bus bytes
   // ------------------------------------------------------------------------
   ssfs_pkg::cfg_type disp_cfg;
   logic [3:0][7:0]   shown_segs;
   bus_beat_type      cmd_beats[$];   // bytes of the command being formatted
   bus_beat_type      bytes_due[$];   // bytes still owed by the block
   disp_cmd_type      cmds_pending[$];

   int  errors        = 0;
   int  cmds_taken    = 0;
   int  beats_checked = 0;
   int  rejected      = 0;
   int  clears        = 0;
   int  settings      = 1;
   bit  quiet         = 1'b0;      // no source gaps or sink stalls

   function automatic logic [7:0] seg_for(input logic [7:0] code);
      return (code < 8'd12) ? DIGIT_SEGS[code[3:0]] : ssfs_pkg::SEG_BLANK;
   endfunction

   // point bit rides on every segment byte sent, never on the stored copy
   function automatic logic [7:0] with_dot(input logic [7:0] seg);
      return seg + (disp_cfg.point_on ? ssfs_pkg::POINT_BIT : 8'h00);
   endfunction

   function automatic logic [7:0] ctrl_byte();
      return ssfs_pkg::CTRL_BASE + {5'd0, disp_cfg.brightness};
   endfunction

   task automatic add_beat(input logic [7:0] b, input logic st, input logic sp);
      bus_beat_type x;
      x.bus_byte     = b;
      x.start_before = st;
      x.stop_after   = sp;
      x.last         = 1'b0;
      cmd_beats.push_back(x);
   endtask

   task automatic frame_four(input logic [3:0][7:0] seg);
      shown_segs = seg;
      add_beat(disp_cfg.auto_data_cmd, 1'b1, 1'b1);
      add_beat(disp_cfg.start_address_cmd, 1'b1, 1'b0);
      for (int i = 0; i < 4; i++)
         add_beat(with_dot(seg[i]), 1'b0, i == 3);
      add_beat(ctrl_byte(), 1'b1, 1'b1);
   endtask

   task automatic frame_one(input logic [1:0] pos, input logic [7:0] seg);
      shown_segs[pos] = seg;
      add_beat(disp_cfg.fixed_data_cmd, 1'b1, 1'b1);
      add_beat(ssfs_pkg::SINGLE_ADDR_BASE | {6'd0, pos}, 1'b1, 1'b0);
      add_beat(with_dot(seg), 1'b0, 1'b1);
      add_beat(ctrl_byte(), 1'b1, 1'b1);
   endtask

   // works out the bus bytes of one accepted command and queues them
   task automatic format_frames(input disp_cmd_type c);
      logic [3:0][7:0] code;
      logic [3:0][7:0] seg;
      bus_beat_type    tail;
      int              v;
      int              a;
      logic            neg;
      logic            done;
      cmd_beats.delete();
      case (c.cmd)
         ssfs_pkg::CMD_FOUR_DIGITS: begin
            for (int i = 0; i < 4; i++)
               seg[i] = seg_for(c.slot[i]);
            frame_four(seg);
         end
         ssfs_pkg::CMD_FOUR_RAW:  frame_four(c.slot);
         ssfs_pkg::CMD_ONE_DIGIT: frame_one(c.position, seg_for(c.slot[0]));
         ssfs_pkg::CMD_ONE_RAW:   frame_one(c.position, c.slot[0]);
         ssfs_pkg::CMD_INTEGER: begin
            v = {{17{c.number[14]}}, c.number};
            if (v > 9999 || v < -999) begin
               rejected++;
            end else begin
               neg = v < 0;
               a   = neg ? -v : v;
               code[0] = 8'(a / 1000);
               code[1] = 8'((a / 100) % 10);
               code[2] = 8'((a / 10) % 10);
               code[3] = 8'(a % 10);
               // blank leading zeros; minus goes just left of the first digit
               done = 1'b0;
               for (int i = 0; i < 3; i++) begin
                  if (!done) begin
                     if (code[i] != 0) begin
                        done = 1'b1;
                     end else if (neg && code[i+1] != 0) begin
                        code[i] = {4'd0, ssfs_pkg::CODE_MINUS};
                        done    = 1'b1;
                     end else begin
                        code[i] = {4'd0, ssfs_pkg::CODE_BLANK};
                     end
                  end
               end
               for (int i = 0; i < 4; i++)
                  seg[i] = seg_for(code[i]);
               frame_four(seg);
            end
         end
         ssfs_pkg::CMD_CLOCK: begin
            if (c.hours > 7'd99 || c.minutes > 7'd99) begin
               rejected++;
            end else begin
               code[0] = (c.hours / 10 == 0) ? {4'd0, ssfs_pkg::CODE_BLANK}
                                             : 8'(c.hours / 10);
               code[1] = 8'(c.hours % 10);
               code[2] = 8'(c.minutes / 10);
               code[3] = 8'(c.minutes % 10);
               for (int i = 0; i < 4; i++)
                  seg[i] = seg_for(code[i]);
               frame_four(seg);
            end
         end
         ssfs_pkg::CMD_REFRESH: frame_four(shown_segs);
         default: begin   // clear
            for (int i = 0; i < 4; i++)
               frame_one(i[1:0], ssfs_pkg::SEG_BLANK);
            shown_segs = '0;
            clears++;
         end
      endcase
      if (cmd_beats.size() > 0) begin
         tail      = cmd_beats[cmd_beats.size()-1];
         tail.last = 1'b1;
         cmd_beats[cmd_beats.size()-1] = tail;
      end
      foreach (cmd_beats[i])
         bytes_due.push_back(cmd_beats[i]);
   endtask

   // ------------------------------------------------------------------------
   // Request driver: one command per transfer, random gap bursts
   // ------------------------------------------------------------------------
   disp_cmd_type cur_cmd;
   int           src_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            format_frames(cur_cmd);
            cmds_taken++;
         end
         // stalled payload stays put; otherwise pick the next step
         if (!req_valid || !req_stall) begin
            if (src_gap > 0) begin
               src_gap--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               src_gap = $urandom_range(1, 6) - 1;
               req_valid <= 1'b0;
            end else if (cmds_pending.size() > 0) begin
               cur_cmd       = cmds_pending.pop_front();
               req_valid    <= 1'b1;
               req_cmd      <= cur_cmd.cmd;
               req_position <= cur_cmd.position;
               req_slot0    <= cur_cmd.slot[0];
               req_slot1    <= cur_cmd.slot[1];
               req_slot2    <= cur_cmd.slot[2];
               req_slot3    <= cur_cmd.slot[3];
               req_number   <= cur_cmd.number;
               req_hours    <= cur_cmd.hours;
               req_minutes  <= cur_cmd.minutes;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: in-order check, random stall bursts, one long hold
   // ------------------------------------------------------------------------
   int snk_gap   = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      bus_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (bytes_due.size() == 0) begin
               $error("unexpected bus byte %0h with no byte owed", rsp_bus_byte);
               errors++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_bus_byte !== want.bus_byte) begin
                  $error("bus_byte: expected %0h, got %0h", want.bus_byte, rsp_bus_byte);
                  errors++;
               end
               if (rsp_start_before !== want.start_before) begin
                  $error("start_before: expected %0b, got %0b",
                         want.start_before, rsp_start_before);
                  errors++;
               end
               if (rsp_stop_after !== want.stop_after) begin
                  $error("stop_after: expected %0b, got %0b",
                         want.stop_after, rsp_stop_after);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  errors++;
               end
            end
         end
         // long hold lets the frame queue fill and back up the request side
         if (!hold_done && cmds_taken >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (snk_gap > 0) begin
            snk_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            snk_gap = $urandom_range(1, 6) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: ends the run when nothing moves for too long
   // ------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d bytes owed",
                  IDLE_LIMIT, bytes_due.size());
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic csr_write(input logic [2:0] idx, input logic [7:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);       // register takes the value at this edge
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         ssfs_pkg::REG_BRIGHTNESS: disp_cfg.brightness        = val[2:0];
         ssfs_pkg::REG_POINT_ON:   disp_cfg.point_on          = val[0];
         ssfs_pkg::REG_START_ADDR: disp_cfg.start_address_cmd = val;
         ssfs_pkg::REG_AUTO_DATA:  disp_cfg.auto_data_cmd     = val;
         ssfs_pkg::REG_FIXED_DATA: disp_cfg.fixed_data_cmd    = val;
         default: ;
      endcase
   endtask

   task automatic add_cmd(input logic [2:0] cmd, input logic [1:0] pos,
                          input logic [31:0] slots, input int num,
                          input logic [6:0] h, input logic [6:0] m);
      disp_cmd_type c;
      c.cmd      = cmd;
      c.position = pos;
      c.slot     = slots;
      c.number   = num[14:0];
      c.hours    = h;
      c.minutes  = m;
      cmds_pending.push_back(c);
   endtask

   // mostly in-range values with random content, some out of range or noise
   function automatic disp_cmd_type rand_cmd();
      disp_cmd_type c;
      int           v;
      c.cmd      = 3'($urandom_range(0, 7));
      c.position = 2'($urandom_range(0, 3));
      for (int i = 0; i < 4; i++)
         c.slot[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 13));
      case ($urandom_range(0, 5))
         0:       v = $urandom_range(0, 32767) - 16384;
         1:       v = $urandom_range(1000, 9999);
         2:       v = -$urandom_range(1, 999);
         3:       v = -$urandom_range(1, 9);
         4:       v = $urandom_range(0, 99);
         default: v = $urandom_range(100, 999);
      endcase
      c.number  = v[14:0];
      c.hours   = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 99));
      c.minutes = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 99));
      return c;
   endfunction

   // wait until every command is in and every byte is out, then let any
   // rejected command still in the pipe clear before registers change;
   // sampled mid-cycle so the edge's updates have all landed
   task automatic drain();
      do
         @(negedge clock);
      while (cmds_pending.size() != 0 || req_valid || bytes_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      ssfs_pkg::cfg_type next_cfg;
      disp_cfg.brightness        = ssfs_pkg::BRIGHTNESS_RST;
      disp_cfg.point_on          = 1'b0;
      disp_cfg.start_address_cmd = ssfs_pkg::START_ADDR_RST;
      disp_cfg.auto_data_cmd     = ssfs_pkg::AUTO_DATA_RST;
      disp_cfg.fixed_data_cmd    = ssfs_pkg::FIXED_DATA_RST;
      shown_segs                 = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: every command, digit code edges, range edges, sign cases
      add_cmd(ssfs_pkg::CMD_FOUR_DIGITS, 2'd0, 32'h03020100, 0, 7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_FOUR_DIGITS, 2'd0, 32'h07060504, 0, 7'd0, 7'd0);
      // blank and minus
      add_cmd(ssfs_pkg::CMD_FOUR_DIGITS, 2'd0, 32'h0b0a0908, 0, 7'd0, 7'd0);
      // codes past the table
      add_cmd(ssfs_pkg::CMD_FOUR_DIGITS, 2'd0, 32'hff80100c, 0, 7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_FOUR_RAW,    2'd0, 32'hffaa5500, 0, 7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_ONE_DIGIT,   2'd0, 32'h00000009, 0, 7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_ONE_DIGIT,   2'd3, 32'h000000c8, 0, 7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_ONE_RAW,     2'd1, 32'h000000ff, 0, 7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_ONE_RAW,     2'd2, 32'h00000000, 0, 7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_INTEGER,     2'd0, 32'h0, 9999,   7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_INTEGER,     2'd0, 32'h0, -999,   7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_INTEGER,     2'd0, 32'h0, 10000,  7'd0, 7'd0);   // rejected
      add_cmd(ssfs_pkg::CMD_INTEGER,     2'd0, 32'h0, -1000,  7'd0, 7'd0);   // rejected
      add_cmd(ssfs_pkg::CMD_INTEGER,     2'd0, 32'h0, 0,      7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_INTEGER,     2'd0, 32'h0, -5,     7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_INTEGER,     2'd0, 32'h0, -50,    7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_INTEGER,     2'd0, 32'h0, 16383,  7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_INTEGER,     2'd0, 32'h0, -16384, 7'd0, 7'd0);
      add_cmd(ssfs_pkg::CMD_CLOCK,       2'd0, 32'h0, 0,      7'd0,   7'd0);
      add_cmd(ssfs_pkg::CMD_CLOCK,       2'd0, 32'h0, 0,      7'd99,  7'd99);
      add_cmd(ssfs_pkg::CMD_CLOCK,       2'd0, 32'h0, 0,      7'd100, 7'd0);   // rejected
      add_cmd(ssfs_pkg::CMD_CLOCK,       2'd0, 32'h0, 0,      7'd5,   7'd127); // rejected
      add_cmd(ssfs_pkg::CMD_REFRESH,     2'd0, 32'h0, 0,      7'd0,   7'd0);
      add_cmd(ssfs_pkg::CMD_CLEAR,       2'd0, 32'h0, 0,      7'd0,   7'd0);
      // shows the cleared state
      add_cmd(ssfs_pkg::CMD_REFRESH,     2'd0, 32'h0, 0,      7'd0,   7'd0);
      drain();

      // random phases, each under a fresh register setting
      for (int ph = 1; ph <= RAND_PHASES; ph++) begin
         case (ph)
            1: next_cfg = {3'd0, 1'b1, 8'h00, 8'hff, 8'h00};
            2: next_cfg = {3'd7, 1'b0, 8'hff, 8'h00, 8'hff};
            default: next_cfg = {3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255))};
         endcase
         csr_write(ssfs_pkg::REG_BRIGHTNESS, {5'd0, next_cfg.brightness});
         csr_write(ssfs_pkg::REG_POINT_ON,   {7'd0, next_cfg.point_on});
         csr_write(ssfs_pkg::REG_START_ADDR, next_cfg.start_address_cmd);
         csr_write(ssfs_pkg::REG_AUTO_DATA,  next_cfg.auto_data_cmd);
         csr_write(ssfs_pkg::REG_FIXED_DATA, next_cfg.fixed_data_cmd);
         settings++;
         if (ph == RAND_PHASES)
            quiet = 1'b1;    // full-rate traffic to finish
         for (int n = 0; n < PHASE_CMDS; n++)
            cmds_pending.push_back(rand_cmd());
         drain();
      end

      if (bytes_due.size() != 0) begin
         $error("%0d bus bytes never arrived", bytes_due.size());
         errors++;
      end

      $display("covered %0d commands (%0d clears, %0d out of range) under %0d settings,",
               cmds_taken, clears, rejected, settings);
      $display("checked %0d bus bytes, %0d mismatches", beats_checked, errors);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
